[rtl/ssdf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssdf_pkg: shared types, codes and tables
// Command codes, the queue entry type and the seven-segment character table.
// ----------------------------------------------------------------------------
package ssdf_pkg;

   localparam int DIGITS_PER_CHIP = 8;
   localparam int BCD_DIGITS      = 10;
   localparam int CONV_STEPS      = 33;

   localparam logic [2:0] CMD_CHAR  = 3'd0;
   localparam logic [2:0] CMD_INT   = 3'd1;
   localparam logic [2:0] CMD_PAD   = 3'd2;
   localparam logic [2:0] CMD_FILL  = 3'd3;
   localparam logic [2:0] CMD_FLUSH = 3'd4;

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'h2d;
   localparam logic [7:0] POINT_BIT   = 8'h80;

   typedef struct packed {
      logic [2:0]         command;
      logic [4:0]         position;
      logic signed [32:0] number_value;
      logic [7:0]         char_code;
      logic               decimal_point;
      logic [3:0]         digit_count;
   } cmd_entry_type;

   function automatic logic [7:0] seg_code(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         8'h20: r = 8'h00;
         8'h30: r = 8'h7e;
         8'h31: r = 8'h30;
         8'h32: r = 8'h6d;
         8'h33: r = 8'h79;
         8'h34: r = 8'h33;
         8'h35: r = 8'h5b;
         8'h36: r = 8'h5f;
         8'h37: r = 8'h70;
         8'h38: r = 8'h7f;
         8'h39: r = 8'h7b;
         8'h2d: r = 8'h01;
         8'h5f: r = 8'h08;
         8'h41: r = 8'h77;
         8'h42: r = 8'h1f;
         8'h43: r = 8'h4e;
         8'h44: r = 8'h3d;
         8'h45: r = 8'h4f;
         8'h46: r = 8'h47;
         8'h47: r = 8'h7b;
         8'h48: r = 8'h37;
         8'h49: r = 8'h06;
         8'h4a: r = 8'h38;
         8'h4b: r = 8'h07;
         8'h4c: r = 8'h0e;
         8'h4d: r = 8'h40;
         8'h4e: r = 8'h15;
         8'h4f: r = 8'h3d;
         8'h50: r = 8'h67;
         8'h51: r = 8'h73;
         8'h52: r = 8'h40;
         8'h53: r = 8'h5b;
         8'h54: r = 8'h0f;
         8'h55: r = 8'h1c;
         8'h56: r = 8'h3e;
         8'h57: r = 8'h3f;
         8'h58: r = 8'h27;
         8'h59: r = 8'h13;
         8'h5a: r = 8'h4d;
         default: r = 8'h49;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/ssdf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssdf_front: command intake
// Accepts request beats, drops unused command codes and queues the rest
// in a two-entry queue toward the execution side.
// ----------------------------------------------------------------------------
module ssdf_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [2:0]             req_command,
   input  wire logic [4:0]             req_position,
   input  wire logic signed [32:0]     req_number_value,
   input  wire logic [7:0]             req_char_code,
   input  wire logic                   req_decimal_point,
   input  wire logic [3:0]             req_digit_count,
   output logic                        q_valid,
   output ssdf_pkg::cmd_entry_type     q_entry,
   input  wire logic                   q_pop
);

   ssdf_pkg::cmd_entry_type entry_ff [2];
   ssdf_pkg::cmd_entry_type entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && (req_command <= ssdf_pkg::CMD_FLUSH);
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in.command       = req_command;
      entry_in.position      = req_position;
      entry_in.number_value  = req_number_value;
      entry_in.char_code     = req_char_code;
      entry_in.decimal_point = req_decimal_point;
      entry_in.digit_count   = req_digit_count;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule
`default_nettype wire

[rtl/ssdf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssdf_back: command execution
// Holds the frame store, converts numbers to decimal with a shift-and-add
// unit, writes digits one per cycle and drives the result register.
// ----------------------------------------------------------------------------
module ssdf_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire ssdf_pkg::cmd_entry_type q_entry,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_result_kind,
   output logic [4:0]                  rsp_next_position,
   output logic [31:0]                 rsp_frame_word,
   output logic                        rsp_last_word
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CONV   = 3'd1;
   localparam logic [2:0] S_SETUP  = 3'd2;
   localparam logic [2:0] S_EMIT   = 3'd3;
   localparam logic [2:0] S_REPORT = 3'd4;
   localparam logic [2:0] S_FLUSH  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic        is_int_ff, is_int_in;
   logic [4:0]  pos_ff, pos_in;
   logic [3:0]  ndig_ff, ndig_in;
   logic [3:0]  dig_ff, dig_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] bin_ff, bin_in;
   logic [39:0] bcd_ff, bcd_in;
   logic [31:0] store_ff [ssdf_pkg::DIGITS_PER_CHIP];
   logic [31:0] store_in [ssdf_pkg::DIGITS_PER_CHIP];

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [4:0]  npos_ff, npos_in;
   logic [31:0] word_ff, word_in;
   logic        last_ff, last_in;
   logic        out_load;

   logic        out_free;
   logic        wr_en;
   logic [4:0]  wr_pos;
   logic [7:0]  wr_code;
   logic        fill_en;
   logic [39:0] bcd_adj;
   logic [3:0]  nib [ssdf_pkg::BCD_DIGITS];
   logic [3:0]  top_idx;
   logic [3:0]  cur_digit;
   logic [32:0] raw;
   logic [7:0]  char_seg;

   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_next_position = npos_ff;
   assign rsp_frame_word    = word_ff;
   assign rsp_last_word     = last_ff;
   assign raw               = q_entry.number_value;

   always_comb begin
      for (int k = 0; k < ssdf_pkg::BCD_DIGITS; k++) begin
         nib[k] = bcd_ff[k*4 +: 4];
         bcd_adj[k*4 +: 4] = (nib[k] >= 4'd5) ? nib[k] + 4'd3 : nib[k];
      end
      top_idx = 4'd0;
      for (int k = 0; k < ssdf_pkg::BCD_DIGITS; k++) begin
         if (nib[k] != 4'd0) begin
            top_idx = 4'(k);
         end
      end
      cur_digit = (dig_ff < 4'(ssdf_pkg::BCD_DIGITS)) ? nib[dig_ff] : 4'd0;
      char_seg  = ssdf_pkg::seg_code(q_entry.char_code);
   end

   always_comb begin
      state_in  = state_ff;
      is_int_in = is_int_ff;
      pos_in    = pos_ff;
      ndig_in   = ndig_ff;
      dig_in    = dig_ff;
      cnt_in    = cnt_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      q_pop     = 1'b0;
      wr_en     = 1'b0;
      wr_pos    = pos_ff;
      wr_code   = 8'd0;
      fill_en   = 1'b0;
      out_load  = 1'b0;
      kind_in   = kind_ff;
      npos_in   = npos_ff;
      word_in   = word_ff;
      last_in   = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               pos_in    = q_entry.position;
               ndig_in   = q_entry.digit_count;
               bcd_in    = 40'd0;
               cnt_in    = 6'(ssdf_pkg::CONV_STEPS);
               is_int_in = (q_entry.command == ssdf_pkg::CMD_INT);
               wr_pos    = q_entry.position;
               priority case (q_entry.command)
                  ssdf_pkg::CMD_CHAR: begin
                     wr_en   = 1'b1;
                     wr_code = q_entry.decimal_point ? (char_seg | ssdf_pkg::POINT_BIT)
                                                     : (char_seg & ~ssdf_pkg::POINT_BIT);
                     if (q_entry.position != 5'd0) begin
                        pos_in = q_entry.position - 5'd1;
                     end
                     state_in = S_REPORT;
                  end
                  ssdf_pkg::CMD_INT: begin
                     if (raw[32]) begin
                        bin_in  = ~raw + 33'd1;
                        wr_en   = 1'b1;
                        wr_code = ssdf_pkg::seg_code(ssdf_pkg::ASCII_MINUS);
                        if (q_entry.position != 5'd0) begin
                           pos_in = q_entry.position - 5'd1;
                        end
                     end else begin
                        bin_in = raw;
                     end
                     state_in = S_CONV;
                  end
                  ssdf_pkg::CMD_PAD: begin
                     bin_in   = {1'b0, raw[31:0]};
                     state_in = (q_entry.digit_count == 4'd0) ? S_REPORT : S_CONV;
                  end
                  ssdf_pkg::CMD_FILL: begin
                     fill_en = 1'b1;
                  end
                  default: begin
                     dig_in   = 4'd0;
                     state_in = S_FLUSH;
                  end
               endcase
            end
         end
         S_CONV: begin
            bcd_in = {bcd_adj[38:0], bin_ff[32]};
            bin_in = {bin_ff[31:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            dig_in   = is_int_ff ? top_idx : ndig_ff - 4'd1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (pos_ff != 5'd0) begin
               wr_en   = 1'b1;
               wr_code = ssdf_pkg::seg_code(ssdf_pkg::ASCII_ZERO + {4'd0, cur_digit});
               pos_in  = pos_ff - 5'd1;
            end
            if (dig_ff == 4'd0) begin
               state_in = S_REPORT;
            end else begin
               dig_in = dig_ff - 4'd1;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = 1'b0;
               npos_in  = pos_ff;
               word_in  = 32'd0;
               last_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = 1'b1;
               npos_in  = 5'd0;
               word_in  = store_ff[dig_ff[2:0]];
               last_in  = (dig_ff[2:0] == 3'd7);
               dig_in   = dig_ff + 4'd1;
               if (dig_ff[2:0] == 3'd7) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Frame store update: a fill rewrites every word, a segment write
   // replaces one byte. Positions 1..8 and 9..16 share the word index.
   always_comb begin
      logic [2:0] idx;
      idx = 3'(wr_pos - 5'd1);
      for (int k = 0; k < ssdf_pkg::DIGITS_PER_CHIP; k++) begin
         store_in[k] = store_ff[k];
         if (fill_en) begin
            store_in[k] = {8'(k + 1), q_entry.char_code, 8'(k + 1), q_entry.char_code};
         end
      end
      if (wr_en && wr_pos != 5'd0 && wr_pos <= 5'd16) begin
         if (wr_pos > 5'd8) begin
            store_in[idx][23:16] = wr_code;
         end else begin
            store_in[idx][7:0] = wr_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < ssdf_pkg::DIGITS_PER_CHIP; k++) begin
            store_ff[k] <= 32'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < ssdf_pkg::DIGITS_PER_CHIP; k++) begin
            store_ff[k] <= store_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      is_int_ff <= is_int_in;
      pos_ff    <= pos_in;
      ndig_ff   <= ndig_in;
      dig_ff    <= dig_in;
      cnt_ff    <= cnt_in;
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      kind_ff   <= kind_in;
      npos_ff   <= npos_in;
      word_ff   <= word_in;
      last_ff   <= last_in;
   end

`ifndef SYNTHESIS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE && q_valid))
      else $error("queue popped outside idle");
   a_conv_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV) |-> (cnt_ff != 6'd0))
      else $error("conversion count underflow");
   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && out_free && dig_ff[2:0] == 3'd7) |=> (state_ff == S_IDLE))
      else $error("flush did not end after the eighth word");
   a_word_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff) |-> (npos_ff == 5'd0))
      else $error("frame word carries a position");
`endif

endmodule
`default_nettype wire

[rtl/seven_segment_digit_frame_builder_unit.sv]
`default_nettype none
// A character print goes from the queue to the report state and then to the result register;
// a number print converts, sets up, then writes one digit per cycle (at most 15) and reports.
// The execution side takes one command at a time and pops the next only when the last is done,
// paced by the 33-step shift-and-add conversion; a flush gives 8 beats, one per cycle unless stalled.
// Reset is synchronous: the queue empties, the result valid clears, the frame store zeros.
// ----------------------------------------------------------------------------
// seven_segment_digit_frame_builder_unit: LED digit frame formatter
// Builds eight frame words for two chained eight-digit segment drivers.
// ----------------------------------------------------------------------------
module seven_segment_digit_frame_builder_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_command,
   input  wire logic [4:0]         req_position,
   input  wire logic signed [32:0] req_number_value,
   input  wire logic [7:0]         req_char_code,
   input  wire logic               req_decimal_point,
   input  wire logic [3:0]         req_digit_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_result_kind,
   output logic [4:0]              rsp_next_position,
   output logic [31:0]             rsp_frame_word,
   output logic                    rsp_last_word
);

   // The front side takes beats and queues commands; commands five to seven
   // are dropped there and never reach the execution side.
   logic                    q_valid;
   logic                    q_pop;
   ssdf_pkg::cmd_entry_type q_entry;

   ssdf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_position      (req_position),
      .req_number_value  (req_number_value),
      .req_char_code     (req_char_code),
      .req_decimal_point (req_decimal_point),
      .req_digit_count   (req_digit_count),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop)
   );

   // The back side owns the frame store and the result register, so a
   // stalled result never blocks the queue from filling.
   ssdf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_next_position (rsp_next_position),
      .rsp_frame_word    (rsp_frame_word),
      .rsp_last_word     (rsp_last_word)
   );

endmodule
`default_nettype wire

[test/ssdf_checker.sv]
// ----------------------------------------------------------------------------
// ssdf_checker: frame builder scoreboard
// Watches both channels, predicts reports and frame words, compares them.
// ----------------------------------------------------------------------------
module ssdf_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [2:0]         req_command,
   input  wire logic [4:0]         req_position,
   input  wire logic signed [32:0] req_number_value,
   input  wire logic [7:0]         req_char_code,
   input  wire logic               req_decimal_point,
   input  wire logic [3:0]         req_digit_count,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic               rsp_result_kind,
   input  wire logic [4:0]         rsp_next_position,
   input  wire logic [31:0]        rsp_frame_word,
   input  wire logic               rsp_last_word,
   output int                      fail_count,
   output int                      pending_count,
   output logic                    accepted
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        kind;
      logic [4:0]  next_pos;
      logic [31:0] word;
      logic        last;
   } beat_type;

   beat_type    expected_beats[$];
   logic [31:0] frame_model[ssdf_pkg::DIGITS_PER_CHIP];

   function automatic logic [7:0] glyph(input logic [7:0] c);
      case (c)
         " ": return 8'h00;  "0": return 8'h7e;  "1": return 8'h30;
         "2": return 8'h6d;  "3": return 8'h79;  "4": return 8'h33;
         "5": return 8'h5b;  "6": return 8'h5f;  "7": return 8'h70;
         "8": return 8'h7f;  "9": return 8'h7b;  "-": return 8'h01;
         "_": return 8'h08;  "A": return 8'h77;  "B": return 8'h1f;
         "C": return 8'h4e;  "D": return 8'h3d;  "E": return 8'h4f;
         "F": return 8'h47;  "G": return 8'h7b;  "H": return 8'h37;
         "I": return 8'h06;  "J": return 8'h38;  "K": return 8'h07;
         "L": return 8'h0e;  "M": return 8'h40;  "N": return 8'h15;
         "O": return 8'h3d;  "P": return 8'h67;  "Q": return 8'h73;
         "R": return 8'h40;  "S": return 8'h5b;  "T": return 8'h0f;
         "U": return 8'h1c;  "V": return 8'h3e;  "W": return 8'h3f;
         "X": return 8'h27;  "Y": return 8'h13;  "Z": return 8'h4d;
         default: return 8'h49;
      endcase
   endfunction

   task automatic place_char(input int pos, input logic [7:0] c, input logic dp);
      logic [7:0] g;
      logic [7:0] code;
      g = glyph(c);
      code = {dp, g[6:0]};
      if (pos >= 1 && pos <= ssdf_pkg::DIGITS_PER_CHIP)
         frame_model[pos-1][7:0] = code;
      else if (pos > ssdf_pkg::DIGITS_PER_CHIP && pos <= 2*ssdf_pkg::DIGITS_PER_CHIP)
         frame_model[pos-ssdf_pkg::DIGITS_PER_CHIP-1][23:16] = code;
   endtask

   task automatic place_digits(inout int pos, input logic [63:0] mag,
                               input logic [63:0] scale);
      while (scale > 0) begin
         if (pos > 0) begin
            place_char(pos, ssdf_pkg::ASCII_ZERO + 8'((mag / scale) % 10), 1'b0);
            pos--;
         end
         scale = scale / 10;
      end
   endtask

   task automatic predict_command(input logic [2:0] cmd, input int pos_in,
                                  input logic [32:0] raw, input logic [7:0] ch,
                                  input logic dp, input logic [3:0] count);
      int          pos;
      logic [63:0] mag;
      logic [63:0] scale;
      beat_type    b;
      pos = pos_in;
      case (cmd)
         ssdf_pkg::CMD_CHAR: begin
            place_char(pos, ch, dp);
            if (pos > 0) pos--;
         end
         ssdf_pkg::CMD_INT: begin
            mag = {31'd0, raw};
            if (raw[32]) begin
               mag = {31'd0, 33'(-raw)};
               if (pos > 0) begin
                  place_char(pos, ssdf_pkg::ASCII_MINUS, 1'b0);
                  pos--;
               end
            end
            scale = 1;
            while (mag / scale > 9) scale = scale * 10;
            place_digits(pos, mag, scale);
         end
         ssdf_pkg::CMD_PAD: begin
            if (count > 0) begin
               scale = 1;
               for (int k = 1; k < count; k++) scale = scale * 10;
               place_digits(pos, {32'd0, raw[31:0]}, scale);
            end
         end
         ssdf_pkg::CMD_FILL: begin
            for (int k = 0; k < ssdf_pkg::DIGITS_PER_CHIP; k++)
               frame_model[k] = {8'(k+1), ch, 8'(k+1), ch};
            return;
         end
         ssdf_pkg::CMD_FLUSH: begin
            for (int k = 0; k < ssdf_pkg::DIGITS_PER_CHIP; k++) begin
               b = '{1'b1, 5'd0, frame_model[k], k == ssdf_pkg::DIGITS_PER_CHIP-1};
               expected_beats.push_back(b);
            end
            return;
         end
         default: return;
      endcase
      b = '{1'b0, 5'(pos), 32'd0, 1'b0};
      expected_beats.push_back(b);
   endtask

   assign pending_count = expected_beats.size();

   always @(posedge clock) begin
      beat_type e;
      int       errs;
      logic     took;
      errs = 0;
      took = 1'b0;
      if (reset) begin
         for (int k = 0; k < ssdf_pkg::DIGITS_PER_CHIP; k++) frame_model[k] = '0;
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            took = 1'b1;
            predict_command(req_command, req_position, req_number_value,
                            req_char_code, req_decimal_point, req_digit_count);
         end
         if (rsp_valid && !rsp_stall) begin
            took = 1'b1;
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat");
               errs++;
            end else begin
               e = expected_beats.pop_front();
               if (rsp_result_kind !== e.kind) begin
                  $error("result_kind exp %0d got %0d", e.kind, rsp_result_kind);
                  errs++;
               end
               if (rsp_next_position !== e.next_pos) begin
                  $error("next_position exp %0d got %0d", e.next_pos, rsp_next_position);
                  errs++;
               end
               if (rsp_frame_word !== e.word) begin
                  $error("frame_word exp %h got %h", e.word, rsp_frame_word);
                  errs++;
               end
               if (rsp_last_word !== e.last) begin
                  $error("last_word exp %0d got %0d", e.last, rsp_last_word);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      accepted <= took;
   end
endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: frame builder testbench top
// Directed and random command beats under bursty input and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_command;
   logic [4:0]         req_position;
   logic signed [32:0] req_number_value;
   logic [7:0]         req_char_code;
   logic               req_decimal_point;
   logic [3:0]         req_digit_count;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_result_kind;
   logic [4:0]         rsp_next_position;
   logic [31:0]        rsp_frame_word;
   logic               rsp_last_word;
   int                 fail_count;
   int                 pending_count;
   logic               accepted;
   logic               long_hold;
   int                 idle_cycles;

   seven_segment_digit_frame_builder_unit dut (.*);
   ssdf_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The watchdog ends the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || accepted) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[seven_segment_digit_frame_builder_unit] ERROR");
            $finish;
         end
      end
   end

   // The receiver stalls on its own random pattern, with quiet stretches. Once,
   // early on, it holds off for a long time so that the input queue fills up.
   initial begin
      int mode;
      rsp_stall = 1'b0;
      long_hold = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (100) @(negedge clock);
      long_hold = 1'b1;
      rsp_stall <= 1'b1;
      repeat (1500) @(negedge clock);
      long_hold = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            @(negedge clock);
            rsp_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
         end
      end
   end

   // Sends one command beat: valid stays up until the beat is taken.
   task automatic send_beat(input logic [2:0] cmd, input logic [4:0] pos,
                            input logic [32:0] num, input logic [7:0] ch,
                            input logic dp, input logic [3:0] count);
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_position      <= pos;
      req_number_value  <= num;
      req_char_code     <= ch;
      req_decimal_point <= dp;
      req_digit_count   <= count;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic random_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clock);
   endtask

   function automatic logic [32:0] random_number();
      case ($urandom_range(0, 5))
         0: return 33'($urandom_range(0, 99));
         1: return -33'($urandom_range(1, 999));
         2: return {1'b0, $urandom()};
         3: return {1'b1, $urandom()};
         4: return 33'h100000000;
         default: return {1'($urandom_range(0, 1)), $urandom()};
      endcase
   endfunction

   initial begin
      int sent;
      int burst;
      logic [2:0] cmd;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = ssdf_pkg::CMD_CHAR;
      req_position      = '0;
      req_number_value  = '0;
      req_char_code     = '0;
      req_decimal_point = 1'b0;
      req_digit_count   = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed beats: table characters, unknown characters, the decimal point,
      // position zero and positions above sixteen, both integer extremes, padding
      // of zero and of more than ten digits, fill, flush and unused codes.
      send_beat(ssdf_pkg::CMD_FLUSH, 5'd0, 33'd0, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_CHAR, 5'd1, 33'd0, "C", 1'b1, 4'd0);
      send_beat(ssdf_pkg::CMD_CHAR, 5'd16, 33'd0, 8'hff, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_CHAR, 5'd0, 33'd0, "A", 1'b1, 4'd0);
      send_beat(ssdf_pkg::CMD_CHAR, 5'd31, 33'd0, "9", 1'b1, 4'd0);
      send_beat(ssdf_pkg::CMD_INT, 5'd16, 33'h100000001, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_FLUSH, 5'd0, 33'd0, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_INT, 5'd16, 33'h100000000, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_INT, 5'd20, 33'h0ffffffff, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_INT, 5'd3, 33'd0, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_INT, 5'd2, -33'sd7, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_PAD, 5'd16, 33'h1ffffffff, 8'h00, 1'b0, 4'd15);
      send_beat(ssdf_pkg::CMD_PAD, 5'd9, 33'd42, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_PAD, 5'd8, 33'd42, 8'h00, 1'b0, 4'd10);
      send_beat(ssdf_pkg::CMD_FLUSH, 5'd0, 33'd0, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_FILL, 5'd0, 33'd0, 8'hff, 1'b1, 4'd0);
      send_beat(3'd5, 5'd1, 33'd0, 8'h00, 1'b0, 4'd0);
      send_beat(3'd7, 5'd31, 33'h1ffffffff, 8'hff, 1'b1, 4'd15);
      send_beat(ssdf_pkg::CMD_FLUSH, 5'd0, 33'd0, 8'h00, 1'b0, 4'd0);
      send_beat(ssdf_pkg::CMD_FILL, 5'd0, 33'd0, 8'h00, 1'b0, 4'd0);
      send_beat(3'd6, 5'd0, 33'd0, 8'h00, 1'b0, 4'd0);

      // Random bursts, mostly real prints at valid positions with a flush now
      // and then; a few beats carry out-of-range positions or unused codes.
      sent = 0;
      while (sent < 200) begin
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4: cmd = ssdf_pkg::CMD_CHAR;
               5, 6, 7, 8, 9: cmd = ssdf_pkg::CMD_INT;
               10, 11, 12, 13: cmd = ssdf_pkg::CMD_PAD;
               14: cmd = ssdf_pkg::CMD_FILL;
               15, 16, 17: cmd = ssdf_pkg::CMD_FLUSH;
               default: cmd = 3'($urandom_range(0, 7));
            endcase
            send_beat(cmd,
                      ($urandom_range(0, 9) == 0) ? 5'($urandom()) :
                                                    5'($urandom_range(0, 16)),
                      random_number(),
                      ($urandom_range(0, 1) == 0) ? 8'($urandom_range(32, 95)) :
                                                    8'($urandom()),
                      1'($urandom()),
                      ($urandom_range(0, 4) == 0) ? 4'($urandom()) :
                                                    4'($urandom_range(0, 10)));
            sent++;
         end
         random_gap();
      end
      req_valid <= 1'b0;

      while (pending_count != 0 || long_hold) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[seven_segment_digit_frame_builder_unit] OK");
      else
         $display("[seven_segment_digit_frame_builder_unit] ERROR");
      $finish;
   end
endmodule

[seven_segment_digit_frame_builder_unit.f]
rtl/ssdf_pkg.sv
rtl/ssdf_front.sv
rtl/ssdf_back.sv
rtl/seven_segment_digit_frame_builder_unit.sv
test/ssdf_checker.sv
test/tb.sv
